// ----- src/sustained_level_trigger_defines.svh -----
// ---------------------------------------------------------------------------
// sustained_level_trigger_defines
// Assertion macros shared by the trigger block.
// ---------------------------------------------------------------------------
`ifndef SUSTAINED_LEVEL_TRIGGER_DEFINES_SVH
`define SUSTAINED_LEVEL_TRIGGER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SLT_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// expression must never hold
`define SLT_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) 1'b1 |-> !(expr)) \
		else $error(msg);

`endif

// ----- src/slt_pkg.sv -----
// ---------------------------------------------------------------------------
// slt_pkg
// Types and constants for the sustained level trigger.
// ---------------------------------------------------------------------------
package slt_pkg;

	// default widths of the time and level fields
	localparam int TIME_WIDTH_DEF  = 48;
	localparam int LEVEL_WIDTH_DEF = 15;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE      = 3'd0,
		CFG_FLOOR_MULT  = 3'd1,
		CFG_FLOOR_MIN   = 3'd2,
		CFG_HOLD_TIME   = 3'd3,
		CFG_COOLDOWN_S  = 3'd4
	} cfg_idx_t;

	// register widths
	localparam int MULT_W     = 8;
	localparam int ABS_W      = 15;
	localparam int SUSTAIN_W  = 16;
	localparam int COOLDOWN_W = 13;

	// scaled register widths (microseconds)
	localparam int SUSTAIN_US_W  = 26;
	localparam int COOLDOWN_US_W = 32;
	localparam int CD_PROD_W     = 33;

	// unit conversions
	localparam logic [9:0]  US_PER_MS = 10'd1000;
	localparam logic [19:0] US_PER_S  = 20'd1000000;

	// reset values
	localparam logic                     ENABLE_RST      = 1'b1;
	localparam logic [MULT_W-1:0]        FLOOR_MULT_RST  = 8'd3;
	localparam logic [ABS_W-1:0]         FLOOR_MIN_RST   = 15'd500;
	localparam logic [SUSTAIN_US_W-1:0]  SUSTAIN_US_RST  = 26'd300000;
	localparam logic [COOLDOWN_US_W-1:0] COOLDOWN_US_RST = 32'd30000000;

	// reported threshold field
	localparam int             THR_W   = 23;
	localparam logic [THR_W-1:0] THR_MAX = 23'h7FFFFF;

endpackage

// ----- src/slt_if.sv -----
// ---------------------------------------------------------------------------
// slt_if
// Valid/ready channels for poll transactions and trigger results.
// ---------------------------------------------------------------------------
interface slt_in_if #(
	parameter int TIME_WIDTH  = slt_pkg::TIME_WIDTH_DEF,
	parameter int LEVEL_WIDTH = slt_pkg::LEVEL_WIDTH_DEF
);
	logic                   valid;
	logic                   ready;
	logic [TIME_WIDTH-1:0]  time_us;
	logic [LEVEL_WIDTH-1:0] level_rms;
	logic [LEVEL_WIDTH-1:0] noise_median;
	logic                   floor_warm;
	logic                   recorder_accepts;

	modport source (output valid, time_us, level_rms, noise_median, floor_warm,
		recorder_accepts, input ready);
	modport sink (input valid, time_us, level_rms, noise_median, floor_warm,
		recorder_accepts, output ready);
endinterface

interface slt_out_if;
	logic                     valid;
	logic                     ready;
	logic                     trigger_request;
	logic                     trigger_taken;
	logic [slt_pkg::THR_W-1:0] threshold;
	logic                     in_cooldown;
	logic                     sustaining;

	modport source (output valid, trigger_request, trigger_taken, threshold,
		in_cooldown, sustaining, input ready);
	modport sink (input valid, trigger_request, trigger_taken, threshold,
		in_cooldown, sustaining, output ready);
endinterface

// ----- src/sustained_level_trigger.sv -----
// Path: a poll is captured in the input register, then its result in the result register.
// Throughput: one poll per cycle unless out_ch stalls; the input register refills while a result waits.
// Per-item path: one 8 x LEVEL_WIDTH multiply and a few TIME_WIDTH subtract/compares.
// Reset: sustain timer stopped, no fire recorded, registers at their defaults.
// ---------------------------------------------------------------------------
// sustained_level_trigger
// Threshold trigger with sustain timer and post-fire cooldown window.
// ---------------------------------------------------------------------------
`include "sustained_level_trigger_defines.svh"

module sustained_level_trigger #(
	parameter int TIME_WIDTH  = slt_pkg::TIME_WIDTH_DEF,
	parameter int LEVEL_WIDTH = slt_pkg::LEVEL_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [slt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [slt_pkg::CFG_DATA_W-1:0] cfg_wdata,
	slt_in_if.sink                         in_ch,
	slt_out_if.source                      out_ch
);

	localparam int THR_FULL_W = slt_pkg::MULT_W + LEVEL_WIDTH;
	localparam int SAT_W = (THR_FULL_W > slt_pkg::THR_W) ? THR_FULL_W : slt_pkg::THR_W;

	// configuration registers
	logic                                 enable_q;
	logic [slt_pkg::MULT_W-1:0]           mult_q;
	logic [slt_pkg::ABS_W-1:0]            floor_min_q;
	logic [slt_pkg::SUSTAIN_US_W-1:0]     sustain_us_q;
	logic [slt_pkg::COOLDOWN_US_W-1:0]    cooldown_us_q;

	logic [slt_pkg::SUSTAIN_US_W-1:0]     sustain_us_new;
	logic [slt_pkg::CD_PROD_W-1:0]        cd_prod;

	// input stage
	logic                   valid_s1;
	logic [TIME_WIDTH-1:0]  time_s1;
	logic [LEVEL_WIDTH-1:0] level_s1;
	logic [LEVEL_WIDTH-1:0] noise_s1;
	logic                   warm_s1;
	logic                   accepts_s1;

	// trigger state
	logic                   above_q;
	logic [TIME_WIDTH-1:0]  above_start_q;
	logic                   fired_q;
	logic [TIME_WIDTH-1:0]  last_fire_q;

	// result register
	logic                      out_valid_q;
	logic                      req_q;
	logic                      taken_q;
	logic [slt_pkg::THR_W-1:0] thr_q;
	logic                      cool_q;
	logic                      sust_q;

	// item logic
	logic                      advance;
	logic [THR_FULL_W-1:0]     thr_prod;
	logic [THR_FULL_W-1:0]     thr_full;
	logic [slt_pkg::THR_W-1:0] thr_sat;
	logic [TIME_WIDTH-1:0]     cool_diff;
	logic [TIME_WIDTH-1:0]     start_time;
	logic [TIME_WIDTH-1:0]     elapsed;
	logic                      is_cool;
	logic                      is_above;
	logic                      met;
	logic                      req_d;
	logic                      taken_d;
	logic                      cool_d;
	logic                      above_d;

	// handshake
	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	// scaled values of the time registers, saturated cooldown
	assign sustain_us_new = slt_pkg::SUSTAIN_US_W'(cfg_wdata[slt_pkg::SUSTAIN_W-1:0])
		* slt_pkg::SUSTAIN_US_W'(slt_pkg::US_PER_MS);
	assign cd_prod = slt_pkg::CD_PROD_W'(cfg_wdata[slt_pkg::COOLDOWN_W-1:0])
		* slt_pkg::CD_PROD_W'(slt_pkg::US_PER_S);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= slt_pkg::ENABLE_RST;
			mult_q        <= slt_pkg::FLOOR_MULT_RST;
			floor_min_q   <= slt_pkg::FLOOR_MIN_RST;
			sustain_us_q  <= slt_pkg::SUSTAIN_US_RST;
			cooldown_us_q <= slt_pkg::COOLDOWN_US_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				slt_pkg::CFG_ENABLE:     enable_q    <= cfg_wdata[0];
				slt_pkg::CFG_FLOOR_MULT: mult_q      <= cfg_wdata[slt_pkg::MULT_W-1:0];
				slt_pkg::CFG_FLOOR_MIN:  floor_min_q <= cfg_wdata[slt_pkg::ABS_W-1:0];
				slt_pkg::CFG_HOLD_TIME:  sustain_us_q <= sustain_us_new;
				slt_pkg::CFG_COOLDOWN_S: begin
					if (cd_prod[slt_pkg::CD_PROD_W-1])
						cooldown_us_q <= '1;
					else
						cooldown_us_q <= cd_prod[slt_pkg::COOLDOWN_US_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			time_s1    <= in_ch.time_us;
			level_s1   <= in_ch.level_rms;
			noise_s1   <= in_ch.noise_median;
			warm_s1    <= in_ch.floor_warm;
			accepts_s1 <= in_ch.recorder_accepts;
		end
	end

	// threshold: max of scaled noise floor and absolute floor, saturated for report
	always_comb begin
		thr_prod = THR_FULL_W'(mult_q) * THR_FULL_W'(noise_s1);
		if (thr_prod < THR_FULL_W'(floor_min_q))
			thr_full = THR_FULL_W'(floor_min_q);
		else
			thr_full = thr_prod;
		if (SAT_W'(thr_full) > SAT_W'(slt_pkg::THR_MAX))
			thr_sat = slt_pkg::THR_MAX;
		else
			thr_sat = slt_pkg::THR_W'(SAT_W'(thr_full));
	end

	// cooldown window and sustain timer
	always_comb begin
		cool_diff  = time_s1 - last_fire_q;
		is_cool    = fired_q && (cool_diff[31:0] < cooldown_us_q);
		is_above   = THR_FULL_W'(level_s1) > thr_full;
		start_time = above_q ? above_start_q : time_s1;
		elapsed    = time_s1 - start_time;
		met        = elapsed >= TIME_WIDTH'(sustain_us_q);

		req_d   = 1'b0;
		taken_d = 1'b0;
		cool_d  = 1'b0;
		above_d = 1'b0;
		if (warm_s1 && enable_q) begin
			if (is_cool) begin
				cool_d = 1'b1;
			end else if (is_above) begin
				if (met) begin
					req_d   = 1'b1;
					taken_d = accepts_s1;
				end else begin
					above_d = 1'b1;
				end
			end
		end
	end

	// trigger state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_q <= 1'b0;
			fired_q <= 1'b0;
		end else if (advance) begin
			above_q <= above_d;
			if (taken_d)
				fired_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			above_start_q <= start_time;
			if (taken_d)
				last_fire_q <= time_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			req_q   <= req_d;
			taken_q <= taken_d;
			thr_q   <= thr_sat;
			cool_q  <= cool_d;
			sust_q  <= above_d;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.trigger_request = req_q;
	assign out_ch.trigger_taken   = taken_q;
	assign out_ch.threshold       = thr_q;
	assign out_ch.in_cooldown     = cool_q;
	assign out_ch.sustaining      = sust_q;

	// checks
	`SLT_ASSERT_IMPL(a_taken_needs_req, out_valid_q && taken_q, req_q, "taken without request")
	`SLT_ASSERT_IMPL(a_cool_no_req, out_valid_q && cool_q, !req_q && !sust_q, "activity in cooldown")
	`SLT_ASSERT_IMPL(a_req_stops_timer, out_valid_q && req_q, !sust_q, "timer kept after request")
	`SLT_ASSERT_NEVER(a_fired_sticky, $fell(fired_q), "fire record lost")

endmodule

// ----- bench/slt_trigger_check_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slt_trigger_check_pkg
// Poll and outcome types plus a scoreboard that predicts the trigger
// decisions from its own copy of the registers and sustain/cooldown state.
// ---------------------------------------------------------------------------
package slt_trigger_check_pkg;

	localparam int TW = slt_pkg::TIME_WIDTH_DEF;
	localparam int LW = slt_pkg::LEVEL_WIDTH_DEF;

	// one poll transaction as the sender drives it
	typedef struct packed {
		logic [TW-1:0] time_us;
		logic [LW-1:0] level_rms;
		logic [LW-1:0] noise_median;
		logic          floor_warm;
		logic          recorder_accepts;
	} poll_t;

	// one outcome transaction as the block returns it
	typedef struct packed {
		logic                      trigger_request;
		logic                      trigger_taken;
		logic [slt_pkg::THR_W-1:0] threshold;
		logic                      in_cooldown;
		logic                      sustaining;
	} trig_outcome_t;

	class trigger_scoreboard;
		// register copies
		bit                           enable;
		bit [slt_pkg::MULT_W-1:0]     floor_mult;
		bit [slt_pkg::ABS_W-1:0]      floor_min;
		bit [slt_pkg::SUSTAIN_W-1:0]  hold_ms;
		bit [slt_pkg::COOLDOWN_W-1:0] cooldown_s;

		// sustain timer and last fire
		bit          timer_running;
		bit [TW-1:0] timer_start;
		bit          has_fired;
		bit [TW-1:0] fire_time;

		trig_outcome_t due_outcomes[$];
		int unsigned   mismatches;

		function new();
			enable        = slt_pkg::ENABLE_RST;
			floor_mult    = slt_pkg::FLOOR_MULT_RST;
			floor_min     = slt_pkg::FLOOR_MIN_RST;
			hold_ms       = 16'd300;
			cooldown_s    = 13'd30;
			timer_running = 1'b0;
			timer_start   = '0;
			has_fired     = 1'b0;
			fire_time     = '0;
			mismatches    = 0;
		endfunction

		// register write, masked to the register width
		function void write_reg(slt_pkg::cfg_idx_t idx,
			logic [slt_pkg::CFG_DATA_W-1:0] val);
			case (idx)
				slt_pkg::CFG_ENABLE:     enable     = val[0];
				slt_pkg::CFG_FLOOR_MULT: floor_mult = val[slt_pkg::MULT_W-1:0];
				slt_pkg::CFG_FLOOR_MIN:  floor_min  = val[slt_pkg::ABS_W-1:0];
				slt_pkg::CFG_HOLD_TIME:  hold_ms    = val[slt_pkg::SUSTAIN_W-1:0];
				slt_pkg::CFG_COOLDOWN_S: cooldown_s = val[slt_pkg::COOLDOWN_W-1:0];
				default: ;
			endcase
		endfunction

		// larger of scaled noise floor and absolute floor
		function bit [slt_pkg::THR_W-1:0] threshold_of(bit [LW-1:0] noise);
			bit [slt_pkg::THR_W-1:0] prod;
			prod = slt_pkg::THR_W'(floor_mult) * slt_pkg::THR_W'(noise);
			return (prod < slt_pkg::THR_W'(floor_min)) ? slt_pkg::THR_W'(floor_min) : prod;
		endfunction

		function int unsigned outstanding();
			return due_outcomes.size();
		endfunction

		// predict the outcome of an accepted poll
		function void note_poll(poll_t p);
			trig_outcome_t           o;
			bit [slt_pkg::THR_W-1:0] thr;
			bit [63:0]               cd_full;
			bit [31:0]               cd_lim;
			bit [TW-1:0]             since_fire;
			bit [TW-1:0]             since_start;
			o = '0;
			thr = threshold_of(p.noise_median);
			o.threshold = thr;
			// cooldown window in us, saturated to 32 bits
			cd_full = 64'(cooldown_s) * 64'd1000000;
			cd_lim = (cd_full > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : cd_full[31:0];
			since_fire = p.time_us - fire_time;
			if (!p.floor_warm || !enable) begin
				timer_running = 1'b0;
			end else if (has_fired && since_fire[31:0] < cd_lim) begin
				o.in_cooldown = 1'b1;
				timer_running = 1'b0;
			end else if (slt_pkg::THR_W'(p.level_rms) > thr) begin
				if (!timer_running) begin
					timer_running = 1'b1;
					timer_start   = p.time_us;
				end
				since_start = p.time_us - timer_start;
				// sustain met: ask, and restart the timer either way
				if (64'(since_start) >= 64'(hold_ms) * 64'd1000) begin
					o.trigger_request = 1'b1;
					if (p.recorder_accepts) begin
						o.trigger_taken = 1'b1;
						has_fired       = 1'b1;
						fire_time       = p.time_us;
					end
					timer_running = 1'b0;
				end
			end else begin
				timer_running = 1'b0;
			end
			o.sustaining = timer_running;
			due_outcomes.push_back(o);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		// compare a returned outcome with the oldest prediction
		function void check_outcome(trig_outcome_t got);
			trig_outcome_t want;
			if (due_outcomes.size() == 0) begin
				$error("outcome transaction with no poll waiting for it");
				mismatches++;
				return;
			end
			want = due_outcomes.pop_front();
			compare_field("trigger_request", 32'(want.trigger_request), 32'(got.trigger_request));
			compare_field("trigger_taken", 32'(want.trigger_taken), 32'(got.trigger_taken));
			compare_field("threshold", 32'(want.threshold), 32'(got.threshold));
			compare_field("in_cooldown", 32'(want.in_cooldown), 32'(got.in_cooldown));
			compare_field("sustaining", 32'(want.sustaining), 32'(got.sustaining));
		endfunction
	endclass

endpackage

// ----- bench/tb_sustained_level_trigger.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_sustained_level_trigger
// Drives poll transactions with random gaps and output stalls, runs the
// trigger through several register settings (extremes included) and checks
// every outcome against the scoreboard's prediction.
// ---------------------------------------------------------------------------
module tb_sustained_level_trigger;

	localparam int          TW          = slt_trigger_check_pkg::TW;
	localparam int          LW          = slt_trigger_check_pkg::LW;
	localparam int unsigned CYCLE_LIMIT = 2000000;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	slt_pkg::cfg_idx_t              cfg_index;
	logic [slt_pkg::CFG_DATA_W-1:0] cfg_wdata;

	slt_in_if  in_ch ();
	slt_out_if out_ch ();

	sustained_level_trigger dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	slt_trigger_check_pkg::trigger_scoreboard sb;
	bit                                       quiet;
	int unsigned                              stall_left;
	int unsigned                              cycles = 0;
	logic [TW-1:0]                            now_us;

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// gap length: mostly none or short, a few long
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// outcome side stalls
	initial begin
		out_ch.ready = 1'b0;
		stall_left   = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	// check each accepted outcome transaction
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_outcome(slt_trigger_check_pkg::trig_outcome_t'({out_ch.trigger_request,
				out_ch.trigger_taken, out_ch.threshold, out_ch.in_cooldown,
				out_ch.sustaining}));
	end

	// present one poll after an optional gap, return once it is accepted
	task automatic send_poll(input slt_trigger_check_pkg::poll_t p, input int unsigned gap);
		if (gap > 0) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid            <= 1'b1;
		in_ch.time_us          <= p.time_us;
		in_ch.level_rms        <= p.level_rms;
		in_ch.noise_median     <= p.noise_median;
		in_ch.floor_warm       <= p.floor_warm;
		in_ch.recorder_accepts <= p.recorder_accepts;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		sb.note_poll(p);
	endtask

	// stop sending and wait for every predicted outcome
	task automatic drain_results();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	// register write, only once the block is idle
	task automatic set_reg(input slt_pkg::cfg_idx_t idx,
		input logic [slt_pkg::CFG_DATA_W-1:0] val);
		drain_results();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, val);
	endtask

	task automatic poll_at(input logic [TW-1:0] t, input int unsigned lvl,
		input int unsigned nse, input bit warm, input bit acc);
		slt_trigger_check_pkg::poll_t p;
		p.time_us          = t;
		p.level_rms        = LW'(lvl);
		p.noise_median     = LW'(nse);
		p.floor_warm       = warm;
		p.recorder_accepts = acc;
		now_us = t;
		send_poll(p, pick_gap());
	endtask

	// directed edge cases
	task automatic run_directed();
		// reset settings: multiplier 3, floor 500, sustain 300 ms, cooldown 30 s
		poll_at(48'd0, 32767, 0, 1'b0, 1'b1);
		poll_at(48'd0, 32767, 0, 1'b1, 1'b1);
		poll_at(48'd100000, 501, 166, 1'b1, 1'b1);
		// sustain met but recorder refuses
		poll_at(48'd300000, 32767, 0, 1'b1, 1'b0);
		// level equal to threshold is not above it
		poll_at(48'd400000, 600, 200, 1'b1, 1'b1);
		poll_at(48'd500000, 32767, 0, 1'b1, 1'b1);
		poll_at(48'd800000, 32767, 0, 1'b1, 1'b1);
		// inside cooldown, up to its last microsecond
		poll_at(48'd900000, 32767, 0, 1'b1, 1'b1);
		poll_at(48'd30799999, 32767, 0, 1'b1, 1'b1);
		poll_at(48'd30800000, 32767, 0, 1'b1, 1'b1);
		poll_at(48'd30900000, 32767, 32767, 1'b1, 1'b1);
		// time going backwards wraps to a long elapsed time
		poll_at(48'd5, 32767, 0, 1'b1, 1'b1);
		poll_at(48'd4, 32767, 0, 1'b1, 1'b1);
		poll_at(48'hFFFF_FFFF_FFFF, 32767, 32767, 1'b1, 1'b1);
		// disabled
		set_reg(slt_pkg::CFG_ENABLE, 16'h0000);
		poll_at(48'd1000, 32767, 0, 1'b1, 1'b1);
		// zero sustain and zero cooldown, largest multiplier
		set_reg(slt_pkg::CFG_ENABLE, 16'h0001);
		set_reg(slt_pkg::CFG_HOLD_TIME, 16'd0);
		set_reg(slt_pkg::CFG_COOLDOWN_S, 16'd0);
		set_reg(slt_pkg::CFG_FLOOR_MULT, 16'd255);
		set_reg(slt_pkg::CFG_FLOOR_MIN, 16'd0);
		poll_at(48'd1000, 32767, 128, 1'b1, 1'b1);
		poll_at(48'd1000, 32767, 128, 1'b1, 1'b1);
		poll_at(48'd1001, 0, 0, 1'b1, 1'b1);
		// saturated cooldown and 32-bit truncation of the time since fire
		set_reg(slt_pkg::CFG_COOLDOWN_S, 16'd8191);
		set_reg(slt_pkg::CFG_FLOOR_MULT, 16'd1);
		set_reg(slt_pkg::CFG_FLOOR_MIN, 16'd32767);
		poll_at(48'd2000, 32767, 0, 1'b1, 1'b1);
		set_reg(slt_pkg::CFG_FLOOR_MIN, 16'd0);
		poll_at(48'd2000, 1, 0, 1'b1, 1'b1);
		poll_at(48'h1_0000_0000 + 48'd2005, 1, 0, 1'b1, 1'b1);
		poll_at(48'h1_0000_0000 + 48'd1999, 1, 0, 1'b1, 1'b1);
	endtask

	// one register setting followed by random polls with loud stretches
	task automatic run_phase(input bit en, input int unsigned mult, input int unsigned abs_lvl,
		input int unsigned sus, input int unsigned cd, input int unsigned step_us,
		input int unsigned count, input bit q);
		int unsigned                  noise_base;
		int unsigned                  nse;
		int unsigned                  thr;
		int unsigned                  lvl;
		int unsigned                  r;
		bit                           loud;
		slt_trigger_check_pkg::poll_t p;
		// spare upper bits of the write data carry junk
		set_reg(slt_pkg::CFG_ENABLE, {15'($urandom), en});
		set_reg(slt_pkg::CFG_FLOOR_MULT, {8'($urandom), 8'(mult)});
		set_reg(slt_pkg::CFG_FLOOR_MIN, {1'($urandom), 15'(abs_lvl)});
		set_reg(slt_pkg::CFG_HOLD_TIME, 16'(sus));
		set_reg(slt_pkg::CFG_COOLDOWN_S, {3'($urandom), 13'(cd)});
		quiet      = q;
		noise_base = $urandom_range(0, 20000 / (mult + 1));
		loud       = 1'b0;
		repeat (count) begin
			// now and then hold off until the block is empty
			if ($urandom_range(0, 99) == 0)
				drain_results();
			// time: steady advance, rare jumps anywhere or past 2^32
			r = $urandom_range(0, 999);
			if (r < 10)
				now_us = TW'({$urandom, $urandom});
			else if (r < 20)
				now_us = now_us + 48'h1_0000_0000 + $urandom_range(0, 3000000);
			else
				now_us = now_us + $urandom_range(0, 2 * step_us);
			if ($urandom_range(0, 19) == 0)
				nse = $urandom_range(0, 32767);
			else
				nse = noise_base + $urandom_range(0, 20);
			thr = sb.threshold_of(LW'(nse));
			if ($urandom_range(0, 99) < 8)
				loud = !loud;
			r = $urandom_range(0, 99);
			if (r < 5 && thr <= 32767)
				lvl = thr;
			else if (r < 10)
				lvl = $urandom_range(0, 32767);
			else if (loud && thr < 32767)
				lvl = $urandom_range(thr + 1, 32767);
			else
				lvl = $urandom_range(0, (thr < 32767) ? thr : 32767);
			p.time_us          = now_us;
			p.level_rms        = LW'(lvl);
			p.noise_median     = LW'(nse);
			p.floor_warm       = ($urandom_range(0, 24) != 0);
			p.recorder_accepts = ($urandom_range(0, 3) != 0);
			send_poll(p, pick_gap());
		end
		quiet = 1'b0;
	endtask

	// main sequence
	initial begin
		int unsigned sus;
		sb                     = new();
		quiet                  = 1'b0;
		now_us                 = '0;
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = slt_pkg::CFG_ENABLE;
		cfg_wdata              = '0;
		in_ch.valid            = 1'b0;
		in_ch.time_us          = '0;
		in_ch.level_rms        = '0;
		in_ch.noise_median     = '0;
		in_ch.floor_warm       = 1'b0;
		in_ch.recorder_accepts = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_directed();

		// low extremes, then typical, then high extremes, then assorted and random settings
		run_phase(1'b1, 1, 0, 0, 0, 50000, 240, 1'b0);
		run_phase(1'b1, 3, 500, 300, 2, 75000, 260, 1'b0);
		run_phase(1'b1, 255, 0, 65535, 8191, 16000000, 220, 1'b0);
		run_phase(1'b1, 1, 32767, 100, 1, 30000, 60, 1'b1);
		run_phase(1'b0, 2, 100, 50, 1, 20000, 120, 1'b0);
		run_phase(1'b1, 2, 100, 200, 1, 60000, 250, 1'b1);
		run_phase(1'b1, 4, 1000, 1000, 4294, 250000, 200, 1'b0);
		run_phase(1'b1, 0, 200, 50, 4295, 20000, 200, 1'b0);
		repeat (2) begin
			sus = $urandom_range(0, 2000);
			run_phase(1'b1, $urandom_range(1, 255), $urandom_range(0, 4000), sus,
				$urandom_range(0, 5), sus * 250 + 20000, 200, 1'b0);
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (sb.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+src
src/slt_pkg.sv
src/slt_if.sv
src/sustained_level_trigger.sv
bench/slt_trigger_check_pkg.sv
bench/tb_sustained_level_trigger.sv
